FILE: hdl/fa_pkg.sv
// shared types and constants for the frame assembler ring queue
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package fa_pkg;

  // item command codes
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_POLL = 2'd2
  } cmd_t;

  // receive mode of the frame gatherer
  typedef enum logic [2:0] {
    MODE_WAIT = 3'b001,
    MODE_RECV = 3'b010,
    MODE_DONE = 3'b100
  } rx_mode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } ctrl_state_t;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // controller to datapath
  typedef struct packed {
    logic do_byte;
    logic do_tick;
    logic do_poll;
    logic pop_begin;
    logic pop_step;
  } fa_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic ring_empty;
    logic pop_last;
  } fa_stat_t;

endpackage

`default_nettype wire

FILE: hdl/fa_item_if.sv
// input item channel: command and received byte
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface fa_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/fa_result_if.sv
// result channel: popped frame bytes and byte status flags
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface fa_result_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       frame_stored;
  logic       oldest_dropped;

  modport source (output valid, output out_valid, output out_byte, output out_last,
                  output frame_stored, output oldest_dropped, input ready);
  modport sink (input valid, input out_valid, input out_byte, input out_last,
                input frame_stored, input oldest_dropped, output ready);
endinterface

`default_nettype wire

FILE: hdl/fa_cfg_if.sv
// configuration write channel for the timeout register
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface fa_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, output timeout_ticks, input ready);
  modport sink (input valid, input timeout_ticks, output ready);
endinterface

`default_nettype wire

FILE: hdl/fa_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hdl/fa_ctrl.sv
// controller: item acceptance, frame pop sequencing and output register valid
// depends on fa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fa_ctrl
  import fa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  output logic          result_valid,
  input  wire logic     result_ready,
  input  wire fa_stat_t status,
  output fa_cmd_t       cmd
);

  ctrl_state_t state, state_next;
  logic        out_full, out_full_next;
  logic        out_free;
  logic        take;
  logic        load_out;

  assign out_free     = !out_full || result_ready;
  assign item_ready   = (state == ST_IDLE) && out_free;
  assign take         = item_valid && item_ready;
  assign result_valid = out_full;

  always_comb begin
    cmd        = '0;
    state_next = state;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          case (status.cmd)
            CMD_BYTE: begin
              cmd.do_byte = 1'b1;
              load_out    = 1'b1;
            end
            CMD_TICK: begin
              cmd.do_tick = 1'b1;
            end
            CMD_POLL: begin
              cmd.do_poll = 1'b1;
              if (status.ring_empty) begin
                load_out = 1'b1;
              end else begin
                cmd.pop_begin = 1'b1;
                state_next    = ST_POP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        // ram data for the current byte is always ready here
        if (out_free) begin
          cmd.pop_step = 1'b1;
          load_out     = 1'b1;
          if (status.pop_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_full_next = 1'b1;
    end else if (result_ready) begin
      out_full_next = 1'b0;
    end else begin
      out_full_next = out_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> !status.ring_empty)
    else $error("pop running on an empty ring");

  a_pop_blocks_items: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_begin |=> (state == ST_POP) && !item_ready)
    else $error("item taken while a frame pop is running");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (out_full && !result_ready) |-> !(cmd.do_byte || cmd.pop_step))
    else $error("output register overwritten before its transfer");

endmodule

`default_nettype wire

FILE: hdl/fa_dp.sv
// datapath: frame gathering counters, ring pointers, timeout timer, frame store
// and the result register; depends on fa_pkg and fa_ram
`timescale 1ns / 1ps
`default_nettype none

module fa_dp
  import fa_pkg::*;
#(
  parameter int FRAME_BYTES = 8,
  parameter int RING_DEPTH  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr,
  input  wire logic [15:0] cfg_data,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  rx_byte,
  input  wire fa_cmd_t     cmd,
  output fa_stat_t         status,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             frame_stored,
  output logic             oldest_dropped
);

  localparam int CW    = $clog2(FRAME_BYTES);
  localparam int SW    = $clog2(RING_DEPTH);
  localparam int DEPTH = RING_DEPTH * FRAME_BYTES;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [CW-1:0] LAST_BYTE = CW'(FRAME_BYTES - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] FB_A      = AW'(FRAME_BYTES);

  logic [15:0]   timeout_ticks;
  logic [15:0]   timer_left;
  rx_mode_t      rx_mode;
  logic [CW-1:0] byte_count;
  logic [SW-1:0] head_slot, tail_slot;
  logic [CW-1:0] rd_idx, rd_idx_next;

  logic [SW-1:0] head_inc, tail_inc;
  logic          frame_done, drop;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data;

  assign head_inc   = (head_slot == LAST_SLOT) ? '0 : head_slot + 1'b1;
  assign tail_inc   = (tail_slot == LAST_SLOT) ? '0 : tail_slot + 1'b1;
  assign frame_done = (byte_count == LAST_BYTE);
  assign drop       = frame_done && (tail_inc == head_slot);

  assign status.cmd        = cmd_t'(command);
  assign status.ring_empty = (head_slot == tail_slot);
  assign status.pop_last   = (rd_idx == LAST_BYTE);

  always_comb begin
    if (cmd.pop_begin) begin
      rd_idx_next = '0;
    end else if (cmd.pop_step) begin
      rd_idx_next = (rd_idx == LAST_BYTE) ? '0 : rd_idx + 1'b1;
    end else begin
      rd_idx_next = rd_idx;
    end
  end

  // read address follows the next index so rd_data matches rd_idx
  assign wr_addr = AW'(tail_slot) * FB_A + AW'(byte_count);
  assign rd_addr = AW'(head_slot) * FB_A + AW'(rd_idx_next);

  fa_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.do_byte),
    .wr_addr(wr_addr),
    .wr_data(rx_byte),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      timer_left    <= '0;
      rx_mode       <= MODE_WAIT;
      byte_count    <= '0;
      head_slot     <= '0;
      tail_slot     <= '0;
      rd_idx        <= '0;
    end else begin
      rd_idx <= rd_idx_next;
      if (cfg_wr) begin
        timeout_ticks <= cfg_data;
      end
      if (cmd.do_byte) begin
        if (rx_mode == MODE_WAIT) begin
          timer_left <= timeout_ticks;
        end
        if (frame_done) begin
          byte_count <= '0;
          rx_mode    <= MODE_DONE;
          tail_slot  <= tail_inc;
          if (drop) begin
            head_slot <= head_inc;
          end
        end else begin
          byte_count <= byte_count + 1'b1;
          if (rx_mode == MODE_WAIT) begin
            rx_mode <= MODE_RECV;
          end
        end
      end
      if (cmd.do_tick && timer_left != '0) begin
        timer_left <= timer_left - 1'b1;
      end
      if (cmd.do_poll) begin
        // expired partial frame is thrown away, tail slot is reused
        if (rx_mode == MODE_RECV && timer_left == '0) begin
          byte_count <= '0;
          rx_mode    <= MODE_WAIT;
        end else if (rx_mode == MODE_DONE) begin
          rx_mode <= MODE_WAIT;
        end
      end
      if (cmd.pop_step && status.pop_last) begin
        head_slot <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_byte) begin
      out_valid      <= 1'b0;
      out_byte       <= '0;
      out_last       <= 1'b1;
      frame_stored   <= frame_done;
      oldest_dropped <= drop;
    end else if (cmd.do_poll) begin
      out_valid      <= 1'b0;
      out_byte       <= '0;
      out_last       <= 1'b1;
      frame_stored   <= 1'b0;
      oldest_dropped <= 1'b0;
    end else if (cmd.pop_step) begin
      out_valid      <= 1'b1;
      out_byte       <= rd_data;
      out_last       <= status.pop_last;
      frame_stored   <= 1'b0;
      oldest_dropped <= 1'b0;
    end
  end

  a_stored_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_byte && frame_done) |=> (head_slot != tail_slot))
    else $error("ring empty right after a frame was queued");

  a_slots_in_range: assert property (@(posedge clk) disable iff (rst)
    (head_slot <= LAST_SLOT) && (tail_slot <= LAST_SLOT) && (byte_count <= LAST_BYTE))
    else $error("ring pointer or byte count out of range");

  a_drop_keeps_gap: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_byte && drop) |=> (head_slot == ((tail_slot == LAST_SLOT) ? '0
                                              : tail_slot + 1'b1)))
    else $error("oldest frame drop left head and tail out of step");

endmodule

`default_nettype wire

FILE: hdl/frame_assembler_ring_queue.sv
// frame assembler ring queue: a received byte gives one result in the cycle after it is taken;
// a tick gives none. a poll of a queued frame reads the frame store, then gives one byte per
// cycle from its read port while the result channel is not stalled; an empty poll gives one
// result. new items wait while a pop streams.
// synchronous reset: ring empty, timer and byte count zero, timeout 1000; store not cleared
`timescale 1ns / 1ps
`default_nettype none

module frame_assembler_ring_queue
  import fa_pkg::*;
#(
  parameter int FRAME_BYTES = 8,
  parameter int RING_DEPTH  = 8
) (
  input wire logic     clk,
  input wire logic     rst,
  fa_item_if.sink      item,
  fa_result_if.source  result,
  fa_cfg_if.sink       cfg
);

  fa_cmd_t  cmd;
  fa_stat_t status;

  // register writes are always taken
  assign cfg.ready = 1'b1;

  fa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .result_valid(result.valid),
    .result_ready(result.ready),
    .status      (status),
    .cmd         (cmd)
  );

  fa_dp #(
    .FRAME_BYTES(FRAME_BYTES),
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg.valid),
    .cfg_data      (cfg.timeout_ticks),
    .command       (item.command),
    .rx_byte       (item.rx_byte),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (result.out_valid),
    .out_byte      (result.out_byte),
    .out_last      (result.out_last),
    .frame_stored  (result.frame_stored),
    .oldest_dropped(result.oldest_dropped)
  );

endmodule

`default_nettype wire
